// ===== sv/intel_hex_record_parser_macros.svh =====
// ----------------------------------------------------------------------------
// Intel HEX record parser assertion macros
// Shared property shorthands, sampled on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_PARSER_MACROS_SVH
`define INTEL_HEX_RECORD_PARSER_MACROS_SVH

// same-cycle implication
`define IHRP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IHRP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ihrp_pkg.sv =====
// ----------------------------------------------------------------------------
// Intel HEX record parser package
// Character codes, result kinds, record types and the front-to-back word.
// ----------------------------------------------------------------------------
package ihrp_pkg;

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_SP    = 8'h20;

	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_COMMIT  = 2'd1;
	localparam logic [1:0] KIND_DISCARD = 2'd2;

	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_ESA  = 8'h02;
	localparam logic [7:0] REC_ELA  = 8'h04;

	localparam logic [9:0] POS_MAX = 10'd1023;

	localparam logic [0:0] CFG_IMAGE_BASE = 1'b0;
	localparam logic [0:0] CFG_IMAGE_SIZE = 1'b1;

	localparam logic [16:0] IMAGE_SIZE_RST = 17'h10000;

	localparam int QUEUE_DEPTH_DEF = 4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] start;
		logic [7:0]  idx;
		logic [7:0]  value;
	} ev_t;

	// bit 4 set: not a hex digit
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		logic [4:0] n;
		n = 5'h10;
		if (c >= 8'h30 && c <= 8'h39)
			n = 5'(c - 8'h30);
		else if (c >= 8'h41 && c <= 8'h46)
			n = 5'(c - 8'h37);
		else if (c >= 8'h61 && c <= 8'h66)
			n = 5'(c - 8'h57);
		return n;
	endfunction

endpackage

// ===== sv/ihrp_front.sv =====
// ----------------------------------------------------------------------------
// Intel HEX record parser front end
// Per-character line state, header decode, checksum and extension handling.
// ----------------------------------------------------------------------------
module ihrp_front import ihrp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_accept,
	input  logic [7:0] text_char,
	input  logic       stream_end,
	output logic       ev_push,
	output ev_t        ev_word
);

	logic [9:0]  pos_q, n_pos;
	logic        ign_q, n_ign;
	logic [3:0]  pend_q, n_pend;
	logic [7:0]  len_q, n_len;
	logic [15:0] off_q, n_off;
	logic [7:0]  rkind_q, n_rkind;
	logic [7:0]  sum_q, n_sum;
	logic [15:0] ext_q, n_ext;
	logic        rbad_q, n_rbad;
	logic [31:0] upper_q, n_upper;
	logic        tail_q, n_tail;

	logic [4:0]  nib;
	logic [7:0]  b;
	logic [9:0]  last;
	logic        have_byte;
	logic        emit;
	logic        line_end;
	logic        ok;
	logic [31:0] start;

	always_comb begin
		n_pos = pos_q; n_ign = ign_q; n_pend = pend_q; n_len = len_q;
		n_off = off_q; n_rkind = rkind_q; n_sum = sum_q; n_ext = ext_q;
		n_rbad = rbad_q; n_upper = upper_q; n_tail = tail_q;
		nib = nibble_of(text_char);
		b = {pend_q, nib[3:0]};
		last = 10'd10 + {1'b0, len_q, 1'b0};
		have_byte = 1'b0;
		emit = 1'b0;
		ok = 1'b0;
		ev_word = '0;
		line_end = (text_char == CHAR_LF) || stream_end;

		if (text_char != CHAR_LF) begin
			if (pos_q != POS_MAX)
				n_pos = pos_q + 10'd1;
			if (pos_q == 10'd0) begin
				if (text_char != CHAR_COLON)
					n_ign = 1'b1;
			end else if (ign_q) begin
				n_ign = 1'b1;
			end else if (pos_q <= 10'd8) begin
				if (nib[4]) begin
					n_ign = 1'b1;
				end else if (pos_q[0]) begin
					n_pend = nib[3:0];
				end else begin
					n_sum = sum_q + b;
					case (pos_q[3:0])
						4'd2: n_len = b;
						4'd4: n_off = {b, off_q[7:0]};
						4'd6: n_off = {off_q[15:8], b};
						default: begin
							n_rkind = b;
							if (b == REC_DATA) begin
								if (len_q == 8'd0)
									n_ign = 1'b1;
							end else if (b == REC_ESA || b == REC_ELA) begin
								if (len_q != 8'd2)
									n_ign = 1'b1;
							end else begin
								n_ign = 1'b1;
							end
						end
					endcase
				end
			end else if (rkind_q == REC_DATA) begin
				if (pos_q <= last && !rbad_q) begin
					if (nib[4]) begin
						n_rbad = 1'b1;
					end else if (pos_q[0]) begin
						n_pend = nib[3:0];
					end else begin
						n_sum = sum_q + b;
						have_byte = (pos_q != last);
					end
				end
			end else if (pos_q <= 10'd12) begin
				if (!rbad_q) begin
					if (nib[4])
						n_rbad = 1'b1;
					else if (pos_q[0])
						n_pend = nib[3:0];
					else
						n_ext = {ext_q[7:0], b};
				end
			end else if (pos_q >= 10'd14 && text_char != CHAR_CR && text_char != CHAR_SP) begin
				n_tail = 1'b1;
			end
		end

		start = upper_q + {16'd0, n_off};
		ok = !n_rbad && (n_sum == 8'd0) && (n_pos >= 10'd11 + {1'b0, n_len, 1'b0});

		if (line_end) begin
			if (!n_ign && n_pos >= 10'd9) begin
				if (n_rkind == REC_DATA) begin
					emit = 1'b1;
					ev_word.kind = ok ? KIND_COMMIT : KIND_DISCARD;
					ev_word.start = start;
				end else if (!n_rbad && n_tail) begin
					if (n_rkind == REC_ELA)
						n_upper = {n_ext, 16'd0};
					else
						n_upper = {12'd0, n_ext, 4'd0};
				end
			end
			n_pos = '0; n_ign = 1'b0; n_pend = '0; n_sum = '0;
			n_rbad = 1'b0; n_tail = 1'b0;
			if (stream_end)
				n_upper = '0;
		end else if (have_byte) begin
			emit = 1'b1;
			ev_word.kind = KIND_DATA;
			ev_word.start = start;
			ev_word.idx = 8'((pos_q - 10'd10) >> 1);
			ev_word.value = b;
		end
	end

	assign ev_push = char_accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; ign_q <= 1'b0; pend_q <= '0; len_q <= '0;
			off_q <= '0; rkind_q <= '0; sum_q <= '0; ext_q <= '0;
			rbad_q <= 1'b0; upper_q <= '0; tail_q <= 1'b0;
		end else if (char_accept) begin
			pos_q <= n_pos; ign_q <= n_ign; pend_q <= n_pend; len_q <= n_len;
			off_q <= n_off; rkind_q <= n_rkind; sum_q <= n_sum; ext_q <= n_ext;
			rbad_q <= n_rbad; upper_q <= n_upper; tail_q <= n_tail;
		end
	end

endmodule

// ===== sv/ihrp_queue.sv =====
// ----------------------------------------------------------------------------
// Intel HEX record parser word queue
// Small FIFO decoupling the character front end from the result back end.
// ----------------------------------------------------------------------------
module ihrp_queue import ihrp_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ev_t  wr_word,
	output logic full,
	output logic valid,
	input  logic pop,
	output ev_t  rd_word
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ev_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign rd_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== sv/ihrp_back.sv =====
// ----------------------------------------------------------------------------
// Intel HEX record parser back end
// Address add, then image window check into the result register.
// ----------------------------------------------------------------------------
module ihrp_back import ihrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] image_base,
	input  logic [16:0] image_size,
	input  logic        ev_valid,
	input  ev_t         ev_word,
	output logic        ev_pop,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [31:0] byte_address,
	output logic [7:0]  byte_value,
	output logic        in_image
);

	logic        v_s1, v_s2;
	logic [1:0]  kind_s1, kind_s2;
	logic [31:0] addr_s1, addr_s2;
	logic [7:0]  val_s1, val_s2;
	logic        in_s2;
	logic        adv_s2;
	logic [31:0] rel;

	assign adv_s2 = !v_s2 || pop;
	assign ev_pop = ev_valid && (!v_s1 || adv_s2);
	assign rel    = addr_s1 - image_base;

	always_ff @(posedge clk) begin
		if (ev_pop) begin
			kind_s1 <= ev_word.kind;
			addr_s1 <= ev_word.start + {24'd0, ev_word.idx};
			val_s1  <= ev_word.value;
		end
		if (adv_s2 && v_s1) begin
			kind_s2 <= kind_s1;
			addr_s2 <= addr_s1;
			val_s2  <= val_s1;
			in_s2   <= (kind_s1 == KIND_DATA) && (rel < {15'd0, image_size});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ev_pop)
				v_s1 <= 1'b1;
			else if (adv_s2)
				v_s1 <= 1'b0;
			if (adv_s2)
				v_s2 <= v_s1;
		end
	end

	assign empty        = !v_s2;
	assign kind         = kind_s2;
	assign byte_address = addr_s2;
	assign byte_value   = val_s2;
	assign in_image     = in_s2;

endmodule

// ===== sv/intel_hex_record_parser.sv =====
// A result is registered in the word queue, then in back-end stages s1 and s2, before it reaches the result ports.
// Throughput: one character per cycle while full is low; the front end updates line state on each accepted character.
// The word queue between front and back absorbs result-side stalls; push sees full once it fills.
// Reset: arst_n clears line state, the upper base, the queue, the result stages and both
// configuration registers (image_base to 0, image_size to 65536).
// ----------------------------------------------------------------------------
// Intel HEX record parser
// Streams HEX text in, emits tentative data bytes and record commit/discard words.
// ----------------------------------------------------------------------------
`include "intel_hex_record_parser_macros.svh"

module intel_hex_record_parser import ihrp_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  text_char,
	input  logic        stream_end,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [31:0] byte_address,
	output logic [7:0]  byte_value,
	output logic        in_image,
	input  logic        cfg_wr_en,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] image_base_q;
	logic [16:0] image_size_q;
	logic        char_accept;
	logic        ev_push;
	ev_t         ev_in;
	ev_t         ev_out;
	logic        q_valid;
	logic        q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_base_q <= '0;
			image_size_q <= IMAGE_SIZE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_IMAGE_BASE: image_base_q <= cfg_data;
				CFG_IMAGE_SIZE: image_size_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	assign char_accept = push && !full;

	ihrp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_accept (char_accept),
		.text_char   (text_char),
		.stream_end  (stream_end),
		.ev_push     (ev_push),
		.ev_word     (ev_in)
	);

	ihrp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (ev_push),
		.wr_word (ev_in),
		.full    (full),
		.valid   (q_valid),
		.pop     (q_pop),
		.rd_word (ev_out)
	);

	ihrp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_base   (image_base_q),
		.image_size   (image_size_q),
		.ev_valid     (q_valid),
		.ev_word      (ev_out),
		.ev_pop       (q_pop),
		.empty        (empty),
		.pop          (pop),
		.kind         (kind),
		.byte_address (byte_address),
		.byte_value   (byte_value),
		.in_image     (in_image)
	);

	`IHRP_ASSERT_IMP(a_no_push_when_full, ev_push, !full, "word pushed into full queue")
	`IHRP_ASSERT_IMP(a_status_clean, !empty && kind != KIND_DATA, byte_value == 8'd0 && !in_image, "status word carries byte data")
	`IHRP_ASSERT_NXT(a_result_held, !empty && !pop, !empty && $stable(byte_address) && $stable(kind), "stalled result lost")

endmodule
